FILE: design/vdib_pkg.sv
// Shared types and constants for the vertex deduplication index builder.
package vdib_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 64;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned IDX_OUT_W        = 6;
  localparam int unsigned CNT_OUT_W        = 7;

  typedef struct packed {
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] norm_x;
    logic [WORD_W-1:0] norm_y;
    logic [WORD_W-1:0] norm_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] vertex_index;
    logic                 is_new;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] unique_count;
    logic                 last_out;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } vdib_state_e;

endpackage

FILE: design/vertex_dedup_index_builder.sv
// Top level of the vertex deduplication index builder.
// Takes one vertex (eight IEEE single words plus an end-of-mesh flag) per
// transaction and returns the index of the first equal stored vertex, or
// appends it and returns the new index; a full table with no match sets
// overflow. The search time is set by the single-ported table read and the
// one compare unit, which visits one stored entry per cycle. A match ends
// the search at the matching entry. While the result register is held by
// output stall, the search waits in its last step. Input stall stays high
// while a vertex is in work. After a vertex with last_vertex set the table
// is empty again.
module vertex_dedup_index_builder #(
  parameter int unsigned MAX_VERTICES = vdib_pkg::DEF_MAX_VERTICES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [vdib_pkg::WORD_W-1:0]        pos_x_i,
  input  logic [vdib_pkg::WORD_W-1:0]        pos_y_i,
  input  logic [vdib_pkg::WORD_W-1:0]        pos_z_i,
  input  logic [vdib_pkg::WORD_W-1:0]        norm_x_i,
  input  logic [vdib_pkg::WORD_W-1:0]        norm_y_i,
  input  logic [vdib_pkg::WORD_W-1:0]        norm_z_i,
  input  logic [vdib_pkg::WORD_W-1:0]        tex_u_i,
  input  logic [vdib_pkg::WORD_W-1:0]        tex_v_i,
  input  logic                               last_vertex_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [vdib_pkg::IDX_OUT_W-1:0]     vertex_index_o,
  output logic                               is_new_o,
  output logic                               overflow_o,
  output logic [vdib_pkg::CNT_OUT_W-1:0]     unique_count_o,
  output logic                               last_out_o
);
  import vdib_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);

  logic             take;
  logic             busy;
  logic             load;
  logic             match;
  logic             out_free;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  vtx_t             vtx_q;
  vtx_t             rdata;
  res_t             res;
  res_t             res_q;
  logic             out_valid_q, out_valid_d;

  assign take     = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (take) begin
      vtx_q <= '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                 norm_x: norm_x_i, norm_y: norm_y_i, norm_z: norm_z_i,
                 tex_u: tex_u_i, tex_v: tex_v_i};
    end
  end

  vdib_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .last_i     (last_vertex_i),
    .match_i    (match),
    .out_free_i (out_free),
    .busy_o     (busy),
    .load_o     (load),
    .ctl_o      (mem_ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .res_o      (res)
  );

  vdib_table #(.MAX_VERTICES(MAX_VERTICES)) u_table (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wdata_i   (vtx_q),
    .rdata_o   (rdata)
  );

  vdib_cmp u_cmp (
    .a_i     (rdata),
    .b_i     (vtx_q),
    .match_o (match)
  );

  assign in_stall_o = busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = res_q.vertex_index;
  assign is_new_o       = res_q.is_new;
  assign overflow_o     = res_q.overflow;
  assign unique_count_o = res_q.unique_count;
  assign last_out_o     = res_q.last_out;

  a_new_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && overflow_o))
    else $error("is_new and overflow both set");

  a_ovf_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (vertex_index_o == '0))
    else $error("overflow with nonzero index");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> in_stall_o)
    else $error("not busy after accepting a vertex");

  a_write_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (load && !mem_ctl.rd_en))
    else $error("table write outside result load");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("result load did not raise output valid");

endmodule

FILE: design/vdib_table.sv
// Unique-vertex table: one write port, one registered read port.
module vdib_table #(
  parameter int unsigned MAX_VERTICES = vdib_pkg::DEF_MAX_VERTICES,
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic               clk_i,
  input  vdib_pkg::mem_ctl_t ctl_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  vdib_pkg::vtx_t     wdata_i,
  output vdib_pkg::vtx_t     rdata_o
);
  import vdib_pkg::*;

  vtx_t mem_q [MAX_VERTICES];
  vtx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/vdib_cmp.sv
// Float-equality compare of one stored vertex against the current vertex.
module vdib_cmp (
  input  vdib_pkg::vtx_t a_i,
  input  vdib_pkg::vtx_t b_i,
  output logic           match_o
);
  import vdib_pkg::*;

  function automatic logic float_eq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    logic nan_a;
    logic nan_b;
    logic both_zero;
    nan_a     = (a[WORD_W-2:0] > 31'h7F80_0000);
    nan_b     = (b[WORD_W-2:0] > 31'h7F80_0000);
    both_zero = ((a[WORD_W-2:0] | b[WORD_W-2:0]) == '0);
    return !nan_a && !nan_b && (both_zero || (a == b));
  endfunction

  assign match_o = float_eq(a_i.pos_x,  b_i.pos_x)  && float_eq(a_i.pos_y,  b_i.pos_y)  &&
                   float_eq(a_i.pos_z,  b_i.pos_z)  && float_eq(a_i.norm_x, b_i.norm_x) &&
                   float_eq(a_i.norm_y, b_i.norm_y) && float_eq(a_i.norm_z, b_i.norm_z) &&
                   float_eq(a_i.tex_u,  b_i.tex_u)  && float_eq(a_i.tex_v,  b_i.tex_v);

endmodule

FILE: design/vdib_seq.sv
// Search sequencer: walks the table one entry per cycle and resolves the result.
module vdib_seq #(
  parameter int unsigned MAX_VERTICES = vdib_pkg::DEF_MAX_VERTICES,
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES),
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic               last_i,
  input  logic               match_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output logic               load_o,
  output vdib_pkg::mem_ctl_t ctl_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic [IDX_W-1:0]   wr_addr_o,
  output vdib_pkg::res_t     res_o
);
  import vdib_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  vdib_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             cmp_valid_q, cmp_valid_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             last_q, last_d;

  logic             full;
  logic             is_new;
  logic             overflow;
  logic [CNT_W-1:0] new_cnt;
  logic [IDX_W-1:0] idx;

  assign full     = (cnt_q == CNT_MAX);
  assign is_new   = !found_q && !full;
  assign overflow = !found_q && full;
  assign new_cnt  = is_new ? cnt_q + CNT_W'(1) : cnt_q;
  assign idx      = found_q ? hit_idx_q : (full ? '0 : cnt_q[IDX_W-1:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if ((cmp_valid_q && match_i) || (rd_ptr_q == cnt_q)) state_d = ST_DONE;
      end
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    last_d      = last_q;
    ctl_o       = '0;
    load_o      = 1'b0;
    busy_o      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (take_i) begin
          rd_ptr_d = '0;
          found_d  = 1'b0;
          last_d   = last_i;
        end
      end
      ST_SCAN: begin
        if (cmp_valid_q && match_i) begin
          found_d   = 1'b1;
          hit_idx_d = cmp_idx_q;
        end else if (rd_ptr_q != cnt_q) begin
          ctl_o.rd_en = 1'b1;
          rd_ptr_d    = rd_ptr_q + CNT_W'(1);
          cmp_valid_d = 1'b1;
          cmp_idx_d   = rd_ptr_q[IDX_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          load_o      = 1'b1;
          ctl_o.wr_en = is_new;
          cnt_d       = last_q ? '0 : new_cnt;
        end
      end
      default: busy_o = 1'b1;
    endcase
  end

  assign rd_addr_o          = rd_ptr_q[IDX_W-1:0];
  assign wr_addr_o          = cnt_q[IDX_W-1:0];
  assign res_o.vertex_index = IDX_OUT_W'(idx);
  assign res_o.is_new       = is_new;
  assign res_o.overflow     = overflow;
  assign res_o.unique_count = CNT_OUT_W'(new_cnt);
  assign res_o.last_out     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      hit_idx_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      found_q     <= found_d;
      hit_idx_q   <= hit_idx_d;
      last_q      <= last_d;
    end
  end

endmodule
